@@ rtl/fia_pkg.sv @@
// Package for the ID allocator: register map, reset values, status codes, config type.
`timescale 1ns / 1ps
`default_nettype none

package fia_pkg;

	// Free queue depth default
	localparam int FIA_FREE_DEPTH = 4096;

	// Configuration port geometry
	localparam int FIA_ADDR_W = 5;
	localparam int FIA_IDX_W  = 3;

	// Register indexes
	localparam logic [FIA_IDX_W-1:0] REG_FIRST_ID      = 3'd0;
	localparam logic [FIA_IDX_W-1:0] REG_ID_STEP       = 3'd1;
	localparam logic [FIA_IDX_W-1:0] REG_LIMIT_SPAN    = 3'd2;
	localparam logic [FIA_IDX_W-1:0] REG_INITIAL_BATCH = 3'd3;
	localparam logic [FIA_IDX_W-1:0] REG_BATCH_SIZE    = 3'd4;

	// Register reset values
	localparam logic [31:0] RST_FIRST_ID      = 32'd0;
	localparam logic [15:0] RST_ID_STEP       = 16'd2;
	localparam logic [31:0] RST_LIMIT_SPAN    = 32'hFFFF_FFFF;
	localparam logic [23:0] RST_INITIAL_BATCH = 24'd25000;
	localparam logic [15:0] RST_BATCH_SIZE    = 16'd1000;

	// Result status codes
	localparam logic [1:0] ST_GRANTED   = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_DROPPED   = 2'd3;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic [31:0] first_id;
		logic [15:0] id_step;
		logic [31:0] limit_span;
		logic [23:0] initial_batch;
		logic [15:0] batch_size;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/fia_cfg_regs.sv @@
// APB-style configuration register bank of the ID allocator.
`timescale 1ns / 1ps
`default_nettype none

module fia_cfg_regs import fia_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [FIA_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t                 cfg_q;
	logic [FIA_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[FIA_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Write registers on the access cycle; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_id      <= RST_FIRST_ID;
			cfg_q.id_step       <= RST_ID_STEP;
			cfg_q.limit_span    <= RST_LIMIT_SPAN;
			cfg_q.initial_batch <= RST_INITIAL_BATCH;
			cfg_q.batch_size    <= RST_BATCH_SIZE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIRST_ID:      cfg_q.first_id      <= pwdata;
				REG_ID_STEP:       cfg_q.id_step       <= pwdata[15:0];
				REG_LIMIT_SPAN:    cfg_q.limit_span    <= pwdata;
				REG_INITIAL_BATCH: cfg_q.initial_batch <= pwdata[23:0];
				REG_BATCH_SIZE:    cfg_q.batch_size    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_FIRST_ID:      prdata = cfg_q.first_id;
			REG_ID_STEP:       prdata = {16'd0, cfg_q.id_step};
			REG_LIMIT_SPAN:    prdata = cfg_q.limit_span;
			REG_INITIAL_BATCH: prdata = {8'd0, cfg_q.initial_batch};
			REG_BATCH_SIZE:    prdata = {16'd0, cfg_q.batch_size};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/fifo_id_allocator.sv @@
// ID allocator: fresh batches of stepped IDs plus a free queue of released IDs.
//
// Usage: each request on the input channel carries action (0 take an ID, 1 give
// one back) and released_id. Every request yields exactly one result on the
// output channel: granted_id, status and the live count after the request.
// Both channels use valid/stall; a request is taken when in_valid is high and
// in_stall is low, a result leaves when out_valid is high and out_stall is low.
// out_valid rises when an accepted request retires from the execute stage into
// the output register. With the output drained, one request is taken every
// cycle; a new request is taken in the same cycle the previous one retires there.
// Released IDs live in a FREE_DEPTH-entry synchronous memory (one write port,
// one read port, registered read). The head entry is read when a request is
// taken and used when that request executes; a release retiring into the very
// entry being read is forwarded around the memory.
// While the output register holds a result and out_stall is high, the request
// in the execute stage waits and in_stall goes high; nothing is lost.
// Reset clears all counters and out_valid, not the memory; no clearing pass is
// needed since only written entries are read. The user must write configuration
// through the APB-style port while the block is idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module fifo_id_allocator import fia_pkg::*; #(
	parameter int FREE_DEPTH = FIA_FREE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [FIA_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// Request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  action,
	input  wire logic [31:0]           released_id,
	// Result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [31:0]           granted_id,
	output logic      [1:0]            status,
	output logic      [31:0]           live_count
);

	localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int CW = $clog2(FREE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FREE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(FREE_DEPTH);

	cfg_t cfg;

	fia_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Allocator state
	logic          primed_q;
	logic [31:0]   next_fresh_q;
	logic [23:0]   fresh_left_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   held_q;

	// Execute stage
	logic          valid_s1;
	logic          action_s1;
	logic [31:0]   rel_id_s1;
	logic [31:0]   rd_data_s1;
	logic          byp_s1;
	logic [31:0]   byp_data_s1;

	// Output register
	logic          out_valid_q;
	logic [31:0]   granted_q;
	logic [1:0]    status_q;
	logic [31:0]   live_q;

	logic [31:0]   free_mem [FREE_DEPTH];

	logic          in_accept;
	logic          out_free;
	logic          s1_fire;
	logic [31:0]   nf_base;
	logic [23:0]   fl_base;
	logic [31:0]   pop_data;
	logic [31:0]   batch_span;
	logic [32:0]   need;
	logic [31:0]   held_inc;
	logic [31:0]   held_dec;
	logic          primed_nxt;
	logic [31:0]   nf_nxt;
	logic [23:0]   fl_nxt;
	logic [31:0]   held_nxt;
	logic [31:0]   grant;
	logic [1:0]    st;
	logic          push;
	logic          pop;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] tail_inc;
	logic [AW-1:0] head_rd;
	logic          wr_en;

	// Handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_fire   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;

	assign out_valid  = out_valid_q;
	assign granted_id = granted_q;
	assign status     = status_q;
	assign live_count = live_q;

	// Pointer wrap for any depth
	assign head_inc = (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == LAST_ADDR) ? '0 : tail_q + AW'(1);

	// Decide the request outcome
	always_comb begin
		nf_base    = primed_q ? next_fresh_q : cfg.first_id;
		fl_base    = primed_q ? fresh_left_q : cfg.initial_batch;
		pop_data   = byp_s1 ? byp_data_s1 : rd_data_s1;
		batch_span = 32'(cfg.batch_size) * 32'(cfg.id_step);
		need       = {1'b0, held_q} + {1'b0, batch_span};
		held_inc   = (held_q == 32'hFFFF_FFFF) ? held_q : held_q + 32'd1;
		held_dec   = (held_q == 32'd0) ? held_q : held_q - 32'd1;

		primed_nxt = primed_q;
		nf_nxt     = next_fresh_q;
		fl_nxt     = fresh_left_q;
		held_nxt   = held_q;
		grant      = 32'd0;
		st         = ST_EXHAUSTED;
		push       = 1'b0;
		pop        = 1'b0;

		if (!action_s1) begin
			primed_nxt = 1'b1;
			nf_nxt     = nf_base;
			fl_nxt     = fl_base;
			if (fl_base != 24'd0) begin
				grant    = nf_base;
				nf_nxt   = nf_base + 32'(cfg.id_step);
				fl_nxt   = fl_base - 24'd1;
				held_nxt = held_inc;
				st       = ST_GRANTED;
			end else if (fill_q != '0) begin
				grant    = pop_data;
				pop      = 1'b1;
				held_nxt = held_inc;
				st       = ST_GRANTED;
			end else if (need >= {1'b0, cfg.limit_span} || cfg.batch_size == 16'd0) begin
				st = ST_EXHAUSTED;
			end else begin
				grant    = nf_base;
				nf_nxt   = nf_base + 32'(cfg.id_step);
				fl_nxt   = 24'(cfg.batch_size) - 24'd1;
				held_nxt = held_inc;
				st       = ST_GRANTED;
			end
		end else if (fill_q >= DEPTH_CNT) begin
			st = ST_DROPPED;
		end else begin
			push     = 1'b1;
			held_nxt = held_dec;
			st       = ST_RELEASED;
		end
	end

	assign wr_en   = s1_fire && push;
	assign head_rd = (s1_fire && pop) ? head_inc : head_q;

	// Free queue memory: write on release, read the head on acceptance
	always_ff @(posedge clk) begin
		if (wr_en) begin
			free_mem[tail_q] <= rel_id_s1;
		end
		if (in_accept) begin
			rd_data_s1 <= free_mem[head_rd];
		end
	end

	// Capture request payload and forward a same-cycle write to the head entry
	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1   <= action;
			rel_id_s1   <= released_id;
			byp_s1      <= wr_en && (tail_q == head_rd);
			byp_data_s1 <= rel_id_s1;
		end
	end

	// Advance the execute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Commit allocator state when the request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			next_fresh_q <= 32'd0;
			fresh_left_q <= 24'd0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			held_q       <= 32'd0;
		end else if (s1_fire) begin
			primed_q     <= primed_nxt;
			next_fresh_q <= nf_nxt;
			fresh_left_q <= fl_nxt;
			held_q       <= held_nxt;
			if (pop) begin
				head_q <= head_inc;
				fill_q <= fill_q - CW'(1);
			end
			if (push) begin
				tail_q <= tail_inc;
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			granted_q <= grant;
			status_q  <= st;
			live_q    <= held_nxt;
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_fifo_id_allocator.sv @@
// Self-checking testbench for the ID allocator: directed table and random phases.
`timescale 1ns / 1ps

module tb_fifo_id_allocator;
	import fia_pkg::*;

	typedef enum logic {ID_TAKE = 1'b0, ID_GIVE = 1'b1} id_action_t;
	typedef enum logic {ROW_WRITE = 1'b0, ROW_ITEM = 1'b1} row_kind_t;

	typedef struct packed {
		logic [31:0] grant;
		logic [1:0]  code;
		logic [31:0] live;
	} alloc_result_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [FIA_IDX_W-1:0] idx;
		logic [31:0]          data;
		id_action_t           act;
		logic                 typed;
		alloc_result_t        want;
	} dir_row_t;

	// Unmapped register slot; writes there must leave every register alone
	localparam logic [FIA_IDX_W-1:0] REG_UNMAPPED = 3'd5;
	localparam int DIR_ROWS = 35;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 325;
	localparam int MAX_PRINTS = 50;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [FIA_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  action = 1'b0;
	logic [31:0]           released_id = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           granted_id;
	logic [1:0]            status;
	logic [31:0]           live_count;

	// Register copies, as the allocator sees them
	logic [31:0] cfg_first_id = RST_FIRST_ID;
	logic [15:0] cfg_id_step = RST_ID_STEP;
	logic [31:0] cfg_limit_span = RST_LIMIT_SPAN;
	logic [23:0] cfg_initial_batch = RST_INITIAL_BATCH;
	logic [15:0] cfg_batch_size = RST_BATCH_SIZE;

	// Allocator state copy
	logic        is_primed = 1'b0;
	logic [31:0] fresh_next = '0;
	logic [23:0] fresh_count = '0;
	logic [31:0] freed_ids[$];
	logic [31:0] held_total = '0;

	alloc_result_t pending_results[$];
	logic [31:0]   held_ids[$];
	int            mismatches = 0;
	logic          in_burst = 1'b0;
	logic          out_burst = 1'b0;
	int            out_wait = 0;
	alloc_result_t want_r;

	dir_row_t dir_table [DIR_ROWS] = '{
		// batch of three just below the top of the ID range, tight span
		'{ROW_WRITE, REG_FIRST_ID,      32'hFFFF_FFF8, ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_ID_STEP,       32'd3,         ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_LIMIT_SPAN,    32'd20,        ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_INITIAL_BATCH, 32'd3,         ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_BATCH_SIZE,    32'd2,         ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_UNMAPPED,      32'd1,         ID_TAKE, 1'b0, '0},
		// give back before any take, with nothing held
		'{ROW_ITEM, '0, 32'hFFFF_FFFF, ID_GIVE, 1'b1, '{32'h0, ST_RELEASED, 32'd0}},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b1, '{32'hFFFF_FFF8, ST_GRANTED, 32'd1}},
		'{ROW_ITEM, '0, 32'hFFFF_FFFF, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h5555_5555, ID_TAKE, 1'b0, '0},
		// primed batch used up: queued ID comes out next
		'{ROW_ITEM, '0, 32'hAAAA_AAAA, ID_TAKE, 1'b1, '{32'hFFFF_FFFF, ST_GRANTED, 32'd4}},
		// new batch starts past the wrap of the ID range
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b1, '{32'h0000_0001, ST_GRANTED, 32'd5}},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		// live count plus one batch reaches the span
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b1, '{32'h0, ST_EXHAUSTED, 32'd14}},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_GIVE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		// zero step: one batch hands out the same value three times
		'{ROW_WRITE, REG_ID_STEP,       32'd0,         ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_BATCH_SIZE,    32'd3,         ID_TAKE, 1'b0, '0},
		'{ROW_WRITE, REG_LIMIT_SPAN,    32'hFFFF_FFFF, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0},
		// zero batch with an empty queue
		'{ROW_WRITE, REG_BATCH_SIZE,    32'd0,         ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b1, '{32'h0, ST_EXHAUSTED, 32'd17}},
		'{ROW_ITEM, '0, 32'h5A5A_A5A5, ID_GIVE, 1'b0, '0},
		// initial batch after priming changes nothing
		'{ROW_WRITE, REG_INITIAL_BATCH, 32'd0,         ID_TAKE, 1'b0, '0},
		'{ROW_ITEM, '0, 32'h0000_0000, ID_TAKE, 1'b0, '0}
	};

	fifo_id_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.released_id(released_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted_id(granted_id),
		.status(status),
		.live_count(live_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Hand out the next fresh ID and advance the batch
	function automatic logic [31:0] take_fresh_id();
		logic [31:0] id;
		id = fresh_next;
		fresh_next = fresh_next + {16'd0, cfg_id_step};
		fresh_count = fresh_count - 24'd1;
		return id;
	endfunction

	// Advance the allocator state by one request and return its result
	function automatic alloc_result_t next_alloc_result(input id_action_t act,
			input logic [31:0] rid);
		alloc_result_t r;
		logic [63:0] need;
		r = '0;
		if (act == ID_TAKE) begin
			if (!is_primed) begin
				is_primed = 1'b1;
				fresh_next = cfg_first_id;
				fresh_count = cfg_initial_batch;
			end
			r.code = ST_GRANTED;
			if (fresh_count != 0) begin
				r.grant = take_fresh_id();
			end else if (freed_ids.size() != 0) begin
				r.grant = freed_ids.pop_front();
			end else begin
				need = {32'd0, held_total} + {48'd0, cfg_batch_size} * {48'd0, cfg_id_step};
				if (need >= {32'd0, cfg_limit_span} || cfg_batch_size == 0) begin
					r.code = ST_EXHAUSTED;
				end else begin
					fresh_count = {8'd0, cfg_batch_size};
					r.grant = take_fresh_id();
				end
			end
			// saturate the live count at the top
			if (r.code == ST_GRANTED && held_total != 32'hFFFF_FFFF)
				held_total = held_total + 32'd1;
		end else begin
			if (freed_ids.size() >= FIA_FREE_DEPTH) begin
				r.code = ST_DROPPED;
			end else begin
				freed_ids.push_back(rid);
				if (held_total != 0)
					held_total = held_total - 32'd1;
				r.code = ST_RELEASED;
			end
		end
		r.live = held_total;
		return r;
	endfunction

	// Write one register over the APB-style port and mirror it
	task automatic write_reg(input logic [FIA_IDX_W-1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FIRST_ID:      cfg_first_id = val;
			REG_ID_STEP:       cfg_id_step = val[15:0];
			REG_LIMIT_SPAN:    cfg_limit_span = val;
			REG_INITIAL_BATCH: cfg_initial_batch = val[23:0];
			REG_BATCH_SIZE:    cfg_batch_size = val[15:0];
			default: ;
		endcase
	endtask

	// Drop valid and wait until every pending result has drained
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Present one request after a random gap, hold it until taken, then predict it
	task automatic send_request(input id_action_t act, input logic [31:0] rid,
			input logic typed, input alloc_result_t fixed);
		int gap;
		alloc_result_t got;
		if ($urandom_range(0, 39) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		released_id <= rid;
		do @(posedge clk); while (in_stall);
		got = next_alloc_result(act, rid);
		pending_results.push_back(typed ? fixed : got);
		if (act == ID_TAKE && got.code == ST_GRANTED)
			held_ids.push_back(got.grant);
	endtask

	// Check each result against the oldest pending one and draw the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result id %h status %0d live %0d",
					granted_id, status, live_count));
			end else begin
				want_r = pending_results.pop_front();
				if (granted_id !== want_r.grant)
					report_mismatch($sformatf("granted_id %h, want %h",
						granted_id, want_r.grant));
				if (status !== want_r.code)
					report_mismatch($sformatf("status %0d, want %0d", status, want_r.code));
				if (live_count !== want_r.live)
					report_mismatch($sformatf("live_count %0d, want %0d",
						live_count, want_r.live));
			end
			if ($urandom_range(0, 39) == 0)
				out_burst = !out_burst;
			out_wait = out_burst ? 0 : $urandom_range(0, 12);
		end
		if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		int phase;
		int n;
		int pick;
		int give_pct;
		logic [31:0] rid;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_WRITE) begin
				settle_idle();
				write_reg(dir_table[i].idx, dir_table[i].data);
			end else begin
				send_request(dir_table[i].act, dir_table[i].data, dir_table[i].typed,
					dir_table[i].want);
			end
		end

		// Random phases, each under its own register setting
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			settle_idle();
			if (phase == 0) begin
				write_reg(REG_FIRST_ID, 32'd0);
				write_reg(REG_ID_STEP, 32'd1);
				write_reg(REG_LIMIT_SPAN, 32'd0);
				write_reg(REG_INITIAL_BATCH, 32'd0);
				write_reg(REG_BATCH_SIZE, 32'd1);
			end else if (phase == 1) begin
				write_reg(REG_FIRST_ID, 32'hFFFF_FFFF);
				write_reg(REG_ID_STEP, 32'd65535);
				write_reg(REG_LIMIT_SPAN, 32'hFFFF_FFFF);
				write_reg(REG_INITIAL_BATCH, 32'h00FF_FFFF);
				write_reg(REG_BATCH_SIZE, 32'd65535);
			end else begin
				write_reg(REG_FIRST_ID, $urandom);
				write_reg(REG_ID_STEP, ($urandom_range(0, 3) == 0) ?
					$urandom_range(1, 65535) : $urandom_range(1, 8));
				write_reg(REG_LIMIT_SPAN, ($urandom_range(0, 1) == 0) ?
					held_total + $urandom_range(0, 200) : $urandom);
				write_reg(REG_INITIAL_BATCH, $urandom_range(0, 24'hFF_FFFF));
				write_reg(REG_BATCH_SIZE, ($urandom_range(0, 3) == 0) ?
					$urandom_range(1, 65535) : $urandom_range(1, 8));
			end
			give_pct = $urandom_range(15, 60);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < give_pct) begin
					// mostly give back an ID that is really held, sometimes junk
					if (held_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
						pick = $urandom_range(0, held_ids.size() - 1);
						rid = held_ids[pick];
						held_ids.delete(pick);
					end else begin
						rid = $urandom;
					end
					send_request(ID_GIVE, rid, 1'b0, '0);
				end else begin
					send_request(ID_TAKE, $urandom, 1'b0, '0);
				end
			end
		end

		settle_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
